@@ hdl/chunked_voxel_store_macros.svh @@
// Assertion macros used by the voxel store datapath.
`ifndef CHUNKED_VOXEL_STORE_MACROS_SVH
`define CHUNKED_VOXEL_STORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CVS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cvs_pkg.sv @@
// Shared constants, codes and control types of the chunked voxel store.
`timescale 1ns / 1ps
`default_nettype none
package cvs_pkg;

   localparam int COORD_BITS      = 16;
   localparam int KIND_FIELD_BITS = 8;

   localparam int CHUNK_EDGE = 16;
   localparam int OFF_BITS   = $clog2(CHUNK_EDGE);
   localparam int CHUNK_BITS = COORD_BITS - OFF_BITS;
   localparam int TAG_BITS   = 3 * CHUNK_BITS;

   localparam int MAX_CHUNKS = 16;
   localparam int SLOT_BITS  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int USED_BITS  = $clog2(MAX_CHUNKS + 1);

   localparam int KIND_BITS = 8;
   localparam int ADDR_BITS = SLOT_BITS + 3 * OFF_BITS;

   localparam logic FUNC_READ   = 1'b0;
   localparam logic FUNC_WRITE  = 1'b1;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic lookup;
      logic finish;
   } cvs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } cvs_stat_type;

endpackage
`default_nettype wire

@@ hdl/cvs_ifs.sv @@
// Request and response channel interfaces of the chunked voxel store.
`timescale 1ns / 1ps
`default_nettype none
interface cvs_req_if;
   import cvs_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          func;
   logic signed [COORD_BITS-1:0]  block_x;
   logic signed [COORD_BITS-1:0]  block_y;
   logic signed [COORD_BITS-1:0]  block_z;
   logic [KIND_FIELD_BITS-1:0]    write_kind;

   modport source (output valid, func, block_x, block_y, block_z, write_kind,
                   input ready);
   modport sink (input valid, func, block_x, block_y, block_z, write_kind,
                 output ready);
endinterface

interface cvs_rsp_if;
   import cvs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [KIND_FIELD_BITS-1:0] read_kind;
   logic                       status;

   modport source (output valid, read_kind, status, input ready);
   modport sink (input valid, read_kind, status, output ready);
endinterface
`default_nettype wire

@@ hdl/cvs_ctrl.sv @@
// Sequencing state machine of the chunked voxel store.
`timescale 1ns / 1ps
`default_nettype none
module cvs_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  cvs_pkg::cvs_stat_type stat,
   output cvs_pkg::cvs_cmd_type  cmd
);
   import cvs_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && stat.out_free);
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.capture    = req_valid && req_ready;
      cmd.lookup     = (state_ff == ST_LOOKUP);
      cmd.finish     = (state_ff == ST_FINISH) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = cmd.capture ? ST_LOOKUP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/cvs_datapath.sv @@
// Coordinate split, chunk directory, block memory and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "chunked_voxel_store_macros.svh"
module cvs_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  cvs_pkg::cvs_cmd_type                  cmd,
   output cvs_pkg::cvs_stat_type                 stat,
   input  wire                                   req_func,
   input  wire signed [cvs_pkg::COORD_BITS-1:0]  req_block_x,
   input  wire signed [cvs_pkg::COORD_BITS-1:0]  req_block_y,
   input  wire signed [cvs_pkg::COORD_BITS-1:0]  req_block_z,
   input  wire [cvs_pkg::KIND_FIELD_BITS-1:0]    req_write_kind,
   input  wire                                   rsp_ready,
   output logic                                  rsp_valid,
   output logic [cvs_pkg::KIND_FIELD_BITS-1:0]   rsp_read_kind,
   output logic                                  rsp_status
);
   import cvs_pkg::*;

   // Captured item.
   logic                    func_ff;
   logic [TAG_BITS-1:0]     tag_key_ff;
   logic [3*OFF_BITS-1:0]   off_ff;
   logic [KIND_BITS-1:0]    kind_ff;

   // Chunk directory.
   logic [MAX_CHUNKS-1:0]   valid_ff;
   logic [TAG_BITS-1:0]     tag_ff [MAX_CHUNKS];
   logic [USED_BITS-1:0]    used_ff;

   // Block memory and its clearing counter.
   logic [KIND_BITS-1:0]    mem [2**ADDR_BITS];
   logic [KIND_BITS-1:0]    rdata_ff;
   logic [ADDR_BITS-1:0]    clr_cnt_ff;

   // Result of the lookup cycle.
   logic                    rsel_ff;
   logic                    pend_status_ff;

   // Result register.
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [KIND_FIELD_BITS-1:0]  read_kind_ff;
   logic                        status_ff;

   logic                    hit;
   logic [SLOT_BITS-1:0]    hit_slot;
   logic                    full;
   logic                    dir_alloc;
   logic                    do_write;
   logic [SLOT_BITS-1:0]    wr_slot;
   logic                    mem_we;
   logic                    mem_re;
   logic [ADDR_BITS-1:0]    mem_addr;
   logic [KIND_BITS-1:0]    mem_wdata;

   // Floor division by the chunk edge is an arithmetic shift; the offset is the low bits.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_func;
         tag_key_ff <= {req_block_x[COORD_BITS-1:OFF_BITS],
                        req_block_y[COORD_BITS-1:OFF_BITS],
                        req_block_z[COORD_BITS-1:OFF_BITS]};
         off_ff     <= {req_block_x[OFF_BITS-1:0], req_block_y[OFF_BITS-1:0],
                        req_block_z[OFF_BITS-1:0]};
         kind_ff    <= KIND_BITS'(req_write_kind);
      end
   end

   // Lowest valid matching entry wins.
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tag_ff[i] == tag_key_ff)) begin
            hit      = 1'b1;
            hit_slot = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      full      = (used_ff == USED_BITS'(MAX_CHUNKS));
      dir_alloc = cmd.lookup && (func_ff == FUNC_WRITE) && !hit && !full;
      do_write  = cmd.lookup && (func_ff == FUNC_WRITE) && (hit || !full);
      wr_slot   = hit ? hit_slot : used_ff[SLOT_BITS-1:0];
      mem_we    = cmd.clear_step || do_write;
      mem_re    = cmd.lookup && (func_ff == FUNC_READ) && hit;
      mem_addr  = cmd.clear_step ? clr_cnt_ff : {wr_slot, off_ff};
      mem_wdata = cmd.clear_step ? '0 : kind_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dir_alloc) begin
         tag_ff[used_ff[SLOT_BITS-1:0]] <= tag_key_ff;
      end
      if (cmd.lookup) begin
         rsel_ff        <= (func_ff == FUNC_READ) && hit;
         pend_status_ff <= ((func_ff == FUNC_WRITE) && !hit && full) ? STATUS_FULL
                                                                      : STATUS_DONE;
      end
      if (cmd.finish) begin
         read_kind_ff <= rsel_ff ? KIND_FIELD_BITS'(rdata_ff) : '0;
         status_ff    <= pend_status_ff;
      end
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dir_alloc) begin
            valid_ff[used_ff[SLOT_BITS-1:0]] <= 1'b1;
            used_ff <= used_ff + 1'b1;
         end
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      stat.clear_last = (clr_cnt_ff == '1);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      rsp_valid       = rsp_valid_ff;
      rsp_read_kind   = read_kind_ff;
      rsp_status      = status_ff;
   end

   `CVS_ASSERT_NOW(a_used_matches_valid, clock, reset, 1'b1,
      $countones(valid_ff) == used_ff, "directory fill count disagrees with valid bits")
   `CVS_ASSERT_NEXT(a_alloc_counts, clock, reset, dir_alloc,
      used_ff == $past(used_ff) + 1'b1, "allocation did not advance the fill count")
   `CVS_ASSERT_NOW(a_result_exclusive, clock, reset, rsp_valid_ff,
      !(status_ff == STATUS_FULL && read_kind_ff != '0), "dropped write carries a kind")

endmodule
`default_nettype wire

@@ hdl/chunked_voxel_store.sv @@
// Top level of the chunked voxel store: controller, datapath and channel wiring.
//
// The block keeps block kinds of a sparse world in chunks of 16x16x16 blocks.
// Each request item carries func (0 read, 1 write), signed world coordinates
// block_x, block_y, block_z and a write_kind. Every request item yields exactly
// one response item with read_kind and status. A read from a chunk that is not
// in the directory answers kind 0. A write to a new chunk takes the next free
// directory entry; with all 16 entries in use it is dropped with status 1.
// Both channels use valid/ready; an item moves on a clock edge with both high.
// Each item passes the lookup state, which registers the directory compare and
// the single-port block memory access, and then the finish state, which loads
// the result into the output register once that register is free.
// The response sits in an output register, so a new request item is taken in
// the same cycle that the previous result is loaded.
// After reset the block memory is swept to zero, one entry per cycle, over all
// 65536 entries; req_chan.ready stays low during the sweep. The directory and
// the response register clear at once. If the receiver stalls, the result
// waits in the output register and at most one more item is taken, which then
// holds until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module chunked_voxel_store (
   input wire         clock,
   input wire         reset,
   cvs_req_if.sink    req_chan,
   cvs_rsp_if.source  rsp_chan
);
   import cvs_pkg::*;

   cvs_cmd_type  cmd;
   cvs_stat_type stat;
   logic         req_ready;

   // The controller owns the request handshake and the sequence of steps.
   cvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the directory, the block memory and the result.
   cvs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_chan.func),
      .req_block_x    (req_chan.block_x),
      .req_block_y    (req_chan.block_y),
      .req_block_z    (req_chan.block_z),
      .req_write_kind (req_chan.write_kind),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_read_kind  (rsp_chan.read_kind),
      .rsp_status     (rsp_chan.status)
   );

   assign req_chan.ready = req_ready;

endmodule
`default_nettype wire

@@ dv/tb_chunked_voxel_store.sv @@
// Self-checking testbench of the chunked voxel store: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_chunked_voxel_store;
   import cvs_pkg::*;

   // Blocks in one chunk, and the part of write_kind that the store keeps.
   localparam int CHUNK_CELLS = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
   localparam int STORE_CELLS = MAX_CHUNKS * CHUNK_CELLS;
   localparam logic [KIND_FIELD_BITS-1:0] KIND_KEEP =
      KIND_FIELD_BITS'((1 << KIND_BITS) - 1);

   // Rows of the directed table either carry a typed-in answer or take the
   // answer from the predictor below.
   localparam bit CHECK_TYPED     = 1'b1;
   localparam bit CHECK_PREDICTED = 1'b0;

   localparam int RANDOM_ITEMS = 850;
   localparam int DRAIN_AT     = 400;
   localparam int SETTLE_CYCLES = 12;

   // After reset the block sweeps all 65536 entries of its memory. On top of that
   // each item costs the idle gap that draw_gap gives at the sender, the stall
   // that it gives at the receiver and its passage through the block. The limit
   // is several times the sum for the whole run.
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic                         func;
      logic signed [COORD_BITS-1:0] block_x;
      logic signed [COORD_BITS-1:0] block_y;
      logic signed [COORD_BITS-1:0] block_z;
      logic [KIND_FIELD_BITS-1:0]   write_kind;
   } voxel_access_type;

   typedef struct packed {
      logic [KIND_FIELD_BITS-1:0] read_kind;
      logic                       status;
   } voxel_answer_type;

   typedef struct packed {
      voxel_access_type access;
      bit               typed;
      voxel_answer_type answer;
   } directed_row_type;

   logic clock;
   logic reset;

   cvs_req_if req_chan ();
   cvs_rsp_if rsp_chan ();

   chunked_voxel_store uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted contents of the block: the chunk directory and the voxel kinds.
   bit                         dir_valid [MAX_CHUNKS];
   logic [3*COORD_BITS-1:0]    dir_tag [MAX_CHUNKS];
   int                         dir_used;
   logic [KIND_FIELD_BITS-1:0] voxel_kind [STORE_CELLS];

   // Answers still owed by the block, oldest first.
   voxel_answer_type answers_due[$];

   // Coordinates written lately; random reads come back to them so that they
   // find real data instead of untouched blocks.
   logic [3*COORD_BITS-1:0] recent_spots[$];

   directed_row_type directed_rows[$];
   int               error_count;
   int               cycle_count;

   // While set, neither side inserts idle cycles.
   bit steady_flow;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Floor division of one world coordinate into a chunk position and an
   // offset inside the chunk. Negative coordinates round toward minus
   // infinity, so -1 falls in chunk -1 at offset CHUNK_EDGE-1.
   function automatic void split_axis(input logic signed [COORD_BITS-1:0] coord,
                                      output int chunk, output int offset);
      int value;
      value = coord;
      if (value >= 0) begin
         chunk = value / CHUNK_EDGE;
      end else begin
         chunk = (value + 1) / CHUNK_EDGE - 1;
      end
      offset = value - CHUNK_EDGE * chunk;
   endfunction

   // Applies one accepted item to the predicted state and returns the answer
   // the block must give for it.
   function automatic voxel_answer_type apply_access(input voxel_access_type acc);
      int                      cx, cy, cz, ox, oy, oz;
      int                      slot, pos, i;
      bit                      hit;
      logic [3*COORD_BITS-1:0] tag;
      voxel_answer_type        ans;
      split_axis(acc.block_x, cx, ox);
      split_axis(acc.block_y, cy, oy);
      split_axis(acc.block_z, cz, oz);
      tag = {cx[COORD_BITS-1:0], cy[COORD_BITS-1:0], cz[COORD_BITS-1:0]};

      // The lowest valid entry with a matching tag wins.
      hit  = 1'b0;
      slot = 0;
      for (i = 0; i < MAX_CHUNKS; i++) begin
         if (!hit && dir_valid[i] && dir_tag[i] == tag) begin
            hit  = 1'b1;
            slot = i;
         end
      end

      ans.read_kind = '0;
      ans.status    = STATUS_DONE;
      if (acc.func == FUNC_READ) begin
         if (hit) begin
            pos = slot * CHUNK_CELLS + (ox * CHUNK_EDGE + oy) * CHUNK_EDGE + oz;
            ans.read_kind = voxel_kind[pos];
         end
         return ans;
      end

      if (!hit) begin
         // A new chunk needs a free directory entry; without one the write
         // is dropped and nothing changes.
         if (dir_used >= MAX_CHUNKS) begin
            ans.status = STATUS_FULL;
            return ans;
         end
         slot            = dir_used;
         dir_valid[slot] = 1'b1;
         dir_tag[slot]   = tag;
         for (i = 0; i < CHUNK_CELLS; i++) begin
            voxel_kind[slot * CHUNK_CELLS + i] = '0;
         end
         dir_used++;
      end
      pos = slot * CHUNK_CELLS + (ox * CHUNK_EDGE + oy) * CHUNK_EDGE + oz;
      voxel_kind[pos] = acc.write_kind & KIND_KEEP;
      return ans;
   endfunction

   function automatic int draw_gap();
      if (steady_flow) begin
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   // Coordinates at the borders of the signed range and of chunks.
   function automatic logic [COORD_BITS-1:0] rim_coord();
      case ($urandom_range(0, 7))
         0: return COORD_BITS'(-32768);
         1: return COORD_BITS'(32767);
         2: return COORD_BITS'(0);
         3: return COORD_BITS'(-1);
         4: return COORD_BITS'(CHUNK_EDGE - 1);
         5: return COORD_BITS'(CHUNK_EDGE);
         6: return COORD_BITS'(-CHUNK_EDGE);
         default: return COORD_BITS'(-CHUNK_EDGE - 1);
      endcase
   endfunction

   // A random block inside a given chunk.
   function automatic logic [COORD_BITS-1:0] coord_in_chunk(input int chunk);
      int value;
      value = chunk * CHUNK_EDGE + $urandom_range(0, CHUNK_EDGE - 1);
      return value[COORD_BITS-1:0];
   endfunction

   // Picks the coordinates of a random item. Most land in chunks the
   // directory already holds, many on blocks written before; the rest spread
   // over the whole signed range or sit on its borders, which mostly misses
   // the directory.
   function automatic logic [3*COORD_BITS-1:0] pick_spot();
      int                      choice, slot, cx, cy, cz;
      logic [3*COORD_BITS-1:0] spot;
      choice = $urandom_range(0, 99);
      if (choice < 35 && recent_spots.size() > 0) begin
         spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
      end else if (choice < 75 && dir_used > 0) begin
         slot = $urandom_range(0, dir_used - 1);
         cx   = $signed(dir_tag[slot][3*COORD_BITS-1:2*COORD_BITS]);
         cy   = $signed(dir_tag[slot][2*COORD_BITS-1:COORD_BITS]);
         cz   = $signed(dir_tag[slot][COORD_BITS-1:0]);
         spot = {coord_in_chunk(cx), coord_in_chunk(cy), coord_in_chunk(cz)};
      end else if (choice < 88) begin
         spot = (3*COORD_BITS)'({$urandom(), $urandom()});
      end else begin
         spot = {rim_coord(), rim_coord(), rim_coord()};
      end
      return spot;
   endfunction

   function automatic voxel_access_type random_access();
      voxel_access_type        acc;
      logic [3*COORD_BITS-1:0] spot;
      int                      pick;
      spot = pick_spot();
      acc.func    = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      acc.block_x = spot[3*COORD_BITS-1:2*COORD_BITS];
      acc.block_y = spot[2*COORD_BITS-1:COORD_BITS];
      acc.block_z = spot[COORD_BITS-1:0];
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         acc.write_kind = '0;
      end else if (pick == 1) begin
         acc.write_kind = '1;
      end else begin
         acc.write_kind = KIND_FIELD_BITS'($urandom());
      end
      return acc;
   endfunction

   task automatic add_row(input logic func, input int bx, input int by, input int bz,
                          input logic [KIND_FIELD_BITS-1:0] kind, input bit typed,
                          input logic [KIND_FIELD_BITS-1:0] want_kind,
                          input logic want_status);
      directed_row_type row;
      row.access.func       = func;
      row.access.block_x    = bx[COORD_BITS-1:0];
      row.access.block_y    = by[COORD_BITS-1:0];
      row.access.block_z    = bz[COORD_BITS-1:0];
      row.access.write_kind = kind;
      row.typed             = typed;
      row.answer.read_kind  = want_kind;
      row.answer.status     = want_status;
      directed_rows = {directed_rows, row};
   endtask

   // Presents one item after a random gap and holds it until the block takes
   // it. The answer owed for it is queued at the accepting edge, in the order
   // the block receives the items. The task returns right after that edge, so
   // the caller may present the next item at once without lowering valid.
   task automatic send_access(input voxel_access_type acc, input bit typed,
                              input voxel_answer_type typed_answer);
      int               gap;
      voxel_answer_type predicted;
      voxel_answer_type owed;
      gap = draw_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= acc.func;
      req_chan.block_x    <= acc.block_x;
      req_chan.block_y    <= acc.block_y;
      req_chan.block_z    <= acc.block_z;
      req_chan.write_kind <= acc.write_kind;
      do @(posedge clock); while (req_chan.ready !== 1'b1);

      // The predictor runs on every item, typed or not, to keep its state.
      predicted = apply_access(acc);
      owed = typed ? typed_answer : predicted;
      answers_due = {answers_due, owed};
      if (acc.func == FUNC_WRITE) begin
         recent_spots = {recent_spots, {acc.block_x, acc.block_y, acc.block_z}};
         if (recent_spots.size() > 64) begin
            void'(recent_spots.pop_front());
         end
      end
   endtask

   task automatic check_answer(input logic [KIND_FIELD_BITS-1:0] got_kind,
                               input logic got_status);
      voxel_answer_type want;
      if (answers_due.size() == 0) begin
         $error("response item with no request pending: read_kind=%0h status=%0b",
                got_kind, got_status);
         error_count++;
      end else begin
         want = answers_due.pop_front();
         if (got_kind !== want.read_kind) begin
            $error("read_kind: expected %0h, got %0h", want.read_kind, got_kind);
            error_count++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, got_status);
            error_count++;
         end
      end
   endtask

   // Receiver: stalls a random number of cycles before each item and checks
   // every response item against the oldest answer owed.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         check_answer(rsp_chan.read_kind, rsp_chan.status);
      end
   end

   // Watchdog on a cycle counter.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("chunked_voxel_store regression: fail");
      $finish;
   end

   // Main sequence.
   initial begin
      voxel_answer_type no_answer;
      int               n, i;
      error_count = 0;
      steady_flow = 1'b0;
      no_answer   = '0;
      dir_used    = 0;
      for (i = 0; i < MAX_CHUNKS; i++) begin
         dir_valid[i] = 1'b0;
      end
      for (i = 0; i < STORE_CELLS; i++) begin
         voxel_kind[i] = '0;
      end

      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.func       <= FUNC_READ;
      req_chan.block_x    <= '0;
      req_chan.block_y    <= '0;
      req_chan.block_z    <= '0;
      req_chan.write_kind <= '0;

      // Directed table. The first rows hit an empty store and the extremes of
      // the coordinate range; the middle rows allocate one new chunk each
      // until all sixteen directory entries are taken; the last rows show
      // that a write to a seventeenth chunk is dropped while writes to chunks
      // already present still work.
      add_row(FUNC_READ,  0, 0, 0, 8'h00, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_READ,  -32768, 32767, -32768, 8'hFF, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 0, 0, 0, 8'hA5, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_READ,  0, 0, 0, 8'h00, CHECK_TYPED, 8'hA5, STATUS_DONE);
      // Block -1 sits at the top offset of chunk -1, block -16 at its bottom.
      add_row(FUNC_WRITE, -1, -1, -1, 8'hFF, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_READ,  -16, -16, -16, 8'h00, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_READ,  -1, -1, -1, 8'h00, CHECK_TYPED, 8'hFF, STATUS_DONE);
      add_row(FUNC_WRITE, -32768, -32768, -32768, 8'h01, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 32767, 32767, 32767, 8'h80, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_READ,  -32768, -32768, -32768, 8'h00, CHECK_TYPED, 8'h01, STATUS_DONE);
      add_row(FUNC_READ,  32767, 32767, 32767, 8'h00, CHECK_TYPED, 8'h80, STATUS_DONE);
      // Writing kind none to an absent chunk still takes a directory entry.
      add_row(FUNC_WRITE, 16, 0, 0, 8'h00, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 0, 16, 0, 8'h11, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 0, 0, 16, 8'h22, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, -17, 15, -16, 8'h33, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 100, -200, 300, 8'h44, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, -1000, 2000, -3000, 8'h55, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 32, 32, 32, 8'h66, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, -32, -32, -32, 8'h77, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 4096, -4096, 4096, 8'h88, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 12345, -12345, 777, 8'h99, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, -20000, 20000, 5, 8'hAA, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 48, 0, 0, 8'hBB, CHECK_PREDICTED, 8'h00, STATUS_DONE);
      // The directory is full now.
      add_row(FUNC_WRITE, 64, 0, 0, 8'hCC, CHECK_TYPED, 8'h00, STATUS_FULL);
      add_row(FUNC_READ,  64, 0, 0, 8'h00, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_WRITE, 0, 0, 0, 8'h7E, CHECK_TYPED, 8'h00, STATUS_DONE);
      add_row(FUNC_READ,  0, 0, 0, 8'h00, CHECK_TYPED, 8'h7E, STATUS_DONE);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The request side stays closed while the memory is swept after reset;
      // send_access simply waits for ready.
      foreach (directed_rows[row_idx]) begin
         send_access(directed_rows[row_idx].access, directed_rows[row_idx].typed,
                     directed_rows[row_idx].answer);
      end

      // Random traffic. The sender pauses twice until every answer is in, and
      // two stretches run with no idle cycles on either side.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 0 || n == DRAIN_AT) begin
            req_chan.valid <= 1'b0;
            while (answers_due.size() != 0) @(posedge clock);
         end
         steady_flow = (n >= 150 && n < 250) || (n >= 650 && n < 700);
         send_access(random_access(), CHECK_PREDICTED, no_answer);
      end
      steady_flow = 1'b0;
      req_chan.valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("chunked_voxel_store regression: pass");
      end else begin
         $display("chunked_voxel_store regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/cvs_pkg.sv
hdl/cvs_ifs.sv
hdl/cvs_ctrl.sv
hdl/cvs_datapath.sv
hdl/chunked_voxel_store.sv
dv/tb_chunked_voxel_store.sv
